/* rtl/ics_pkg.sv */
// Shared types and constants for the indexed canvas scaler.
// Used by every file of the block but ics_ram and ics_queue; depends on nothing.

package ics_pkg;

   // Default sizes of the stores.
   localparam int MAX_CANVAS_W_DEF  = 256;
   localparam int MAX_CANVAS_H_DEF  = 256;
   localparam int PALETTE_DEPTH_DEF = 256;

   // Field widths of the channels.
   localparam int FUNC_W  = 2;
   localparam int POS_W   = 11;
   localparam int INDEX_W = 8;
   localparam int RGB_W   = 24;
   localparam int ARGB_W  = 32;

   // Configuration register widths.
   localparam int CANVAS_REG_W = 9;
   localparam int SCREEN_REG_W = 12;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 12;

   // Fixed-point scaling: step is 9.8, the mapped coordinate drops the fraction.
   localparam int FRAC_W = 8;
   localparam int STEP_W = CANVAS_REG_W + FRAC_W;
   localparam int PROD_W = POS_W + STEP_W;
   localparam int MAP_W  = PROD_W - FRAC_W;

   // Depth of the queue between the front and back parts.
   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   // Selector codes of the input channel.
   typedef enum logic [FUNC_W-1:0] {
      FUNC_PALETTE = 2'd0,
      FUNC_CANVAS  = 2'd1,
      FUNC_RENDER  = 2'd2,
      FUNC_NONE    = 2'd3
   } func_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_CANVAS_W  = 3'd0,
      REG_CANVAS_H  = 3'd1,
      REG_SCREEN_W  = 3'd2,
      REG_SCREEN_H  = 3'd3,
      REG_STRETCH   = 3'd4
   } reg_index_type;

   // Operations handed from the front part to the back part.
   typedef enum logic [1:0] {
      OP_PALETTE,
      OP_CANVAS,
      OP_RENDER
   } op_type;

   // Fixed part of one queued command; coordinates travel beside it.
   typedef struct packed {
      op_type               op;
      logic                 hit;
      logic [INDEX_W-1:0]   idx;
      logic [RGB_W-1:0]     rgb;
   } cmd_type;

   // Status of the front part's step computation.
   typedef struct packed {
      logic step_pending;
      logic step_busy;
   } front_status_type;

endpackage

/* rtl/ics_channels.sv */
// Channel interfaces of the indexed canvas scaler: request, response, CSR write.
// Depends on ics_pkg for field widths.

interface ics_req_if;
   logic                              valid;
   logic                              ready;
   logic [ics_pkg::FUNC_W-1:0]        func;
   logic [ics_pkg::POS_W-1:0]         pos_x;
   logic [ics_pkg::POS_W-1:0]         pos_y;
   logic [ics_pkg::INDEX_W-1:0]       color_index;
   logic [ics_pkg::RGB_W-1:0]         rgb_value;
   logic [ics_pkg::INDEX_W-1:0]       transparent_index;
   logic                              transparency_on;
   logic                              restore_background;
   logic [ics_pkg::INDEX_W-1:0]       background_index;

   modport source (output valid, func, pos_x, pos_y, color_index, rgb_value,
                   transparent_index, transparency_on, restore_background,
                   background_index, input ready);
   modport sink (input valid, func, pos_x, pos_y, color_index, rgb_value,
                 transparent_index, transparency_on, restore_background,
                 background_index, output ready);
endinterface

interface ics_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ics_pkg::ARGB_W-1:0]   argb_pixel;
   logic                         covered;

   modport source (output valid, argb_pixel, covered, input ready);
   modport sink (input valid, argb_pixel, covered, output ready);
endinterface

interface ics_csr_if;
   logic                             valid;
   logic                             ready;
   logic [ics_pkg::CSR_INDEX_W-1:0]  reg_index;
   logic [ics_pkg::CSR_DATA_W-1:0]   write_data;

   modport source (output valid, reg_index, write_data, input ready);
   modport sink (input valid, reg_index, write_data, output ready);
endinterface

/* rtl/ics_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; used for the canvas and palette stores.

module ics_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/ics_div.sv */
// Restoring divider, one quotient bit per cycle, for the 9.8 scaling step.
// Depends on ics_pkg for operand widths.

module ics_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [ics_pkg::STEP_W-1:0]         dividend,
   input  logic [ics_pkg::SCREEN_REG_W-1:0]   divisor,
   output logic                               busy,
   output logic [ics_pkg::STEP_W-1:0]         quotient
);

   localparam int QW  = ics_pkg::STEP_W;
   localparam int DW  = ics_pkg::SCREEN_REG_W;
   localparam int CNW = $clog2(QW + 1);

   logic           busy_ff, busy_in;
   logic [CNW-1:0] count_ff, count_in;
   logic [QW-1:0]  quot_ff, quot_in;
   logic [DW-1:0]  rem_ff, rem_in;
   logic [DW-1:0]  div_ff, div_in;
   logic [DW:0]    trial;
   logic [DW:0]    diff;
   logic           ge;

   // One restoring step: shift in the next dividend bit and try a subtract.
   always_comb begin
      trial = {rem_ff, quot_ff[QW-1]};
      diff  = trial - {1'b0, div_ff};
      ge    = trial >= {1'b0, div_ff};
   end

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNW'(QW);
         quot_in  = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         quot_in  = {quot_ff[QW-2:0], ge};
         rem_in   = ge ? diff[DW-1:0] : trial[DW-1:0];
         count_in = count_ff - 1'b1;
         if (count_ff == CNW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quot_ff;

endmodule

/* rtl/ics_queue.sv */
// Small register-based FIFO between the front and back parts.
// Standalone; width and depth come from the instantiating module.

module ics_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PW  = $clog2(DEPTH);
   localparam int CNW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNW-1:0]   count_ff, count_in;
   logic             push_fire;
   logic             pop_fire;

   assign push_ready = count_ff != CNW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // Pointer and fill-count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/ics_front.sv */
// Front part: configuration registers, scaling-step dividers, request intake
// and classification into queued commands. Depends on ics_pkg, ics_channels, ics_div.

module ics_front #(
   parameter int MAX_CANVAS_W  = ics_pkg::MAX_CANVAS_W_DEF,
   parameter int MAX_CANVAS_H  = ics_pkg::MAX_CANVAS_H_DEF,
   parameter int PALETTE_DEPTH = ics_pkg::PALETTE_DEPTH_DEF,
   localparam int CXW = $clog2(MAX_CANVAS_W),
   localparam int CYW = $clog2(MAX_CANVAS_H)
) (
   input  logic                        clock,
   input  logic                        reset,
   ics_csr_if.sink                     csr,
   ics_req_if.sink                     req,
   output ics_pkg::cmd_type            q_cmd,
   output logic [CXW-1:0]              q_cx,
   output logic [CYW-1:0]              q_cy,
   output logic                        q_valid,
   input  logic                        q_ready,
   output ics_pkg::front_status_type   status
);

   localparam int CRW   = ics_pkg::CANVAS_REG_W;
   localparam int SRW   = ics_pkg::SCREEN_REG_W;
   localparam int CMP_W = ics_pkg::POS_W;
   localparam int PCW   = ics_pkg::INDEX_W + 1;
   localparam int FW    = ics_pkg::FRAC_W;
   localparam int PRW   = ics_pkg::PROD_W;
   localparam int MW    = ics_pkg::MAP_W;
   localparam int SW    = ics_pkg::STEP_W;

   // Configuration registers.
   logic [CRW-1:0] cw_ff, cw_in;
   logic [CRW-1:0] ch_ff, ch_in;
   logic [SRW-1:0] sw_ff, sw_in;
   logic [SRW-1:0] sh_ff, sh_in;
   logic           stretch_ff, stretch_in;
   logic           pending_ff, pending_in;

   // Effective sizes and scaling steps.
   logic [CRW-1:0] cw_eff, ch_eff;
   logic [SRW-1:0] sw_eff, sh_eff;
   logic [SW-1:0]  step_x, step_y;
   logic           busy_x, busy_y;
   logic           div_start;

   // Intake stage.
   logic                          st_valid_ff, st_valid_in;
   logic [ics_pkg::FUNC_W-1:0]    st_func_ff;
   logic [ics_pkg::POS_W-1:0]     st_px_ff, st_py_ff;
   logic [ics_pkg::INDEX_W-1:0]   st_ci_ff, st_trans_ff, st_bg_ff;
   logic [ics_pkg::RGB_W-1:0]     st_rgb_ff;
   logic                          st_trans_on_ff, st_restore_ff;
   logic [PRW-1:0]                st_prod_x_ff, st_prod_y_ff;
   logic [PRW-1:0]                prod_x_in, prod_y_in;

   logic          req_fire;
   logic          need_push;
   logic          st_done;
   logic          is_render;
   logic          is_trans;
   logic          in_canvas;
   logic [MW-1:0] coord_x, coord_y;

   // CSR writes; any write asks for the steps to be recomputed.
   assign csr.ready = 1'b1;

   always_comb begin
      cw_in      = cw_ff;
      ch_in      = ch_ff;
      sw_in      = sw_ff;
      sh_in      = sh_ff;
      stretch_in = stretch_ff;
      pending_in = pending_ff && !div_start;
      if (csr.valid) begin
         pending_in = 1'b1;
         case (csr.reg_index)
            ics_pkg::REG_CANVAS_W: cw_in      = csr.write_data[CRW-1:0];
            ics_pkg::REG_CANVAS_H: ch_in      = csr.write_data[CRW-1:0];
            ics_pkg::REG_SCREEN_W: sw_in      = csr.write_data[SRW-1:0];
            ics_pkg::REG_SCREEN_H: sh_in      = csr.write_data[SRW-1:0];
            ics_pkg::REG_STRETCH:  stretch_in = csr.write_data[0];
            default: ;
         endcase
      end
   end

   // Clamp the canvas size to 1..max and the screen size to at least 1.
   always_comb begin
      if (cw_ff == '0) begin
         cw_eff = CRW'(1);
      end else if (CMP_W'(cw_ff) > CMP_W'(MAX_CANVAS_W)) begin
         cw_eff = CRW'(MAX_CANVAS_W);
      end else begin
         cw_eff = cw_ff;
      end
      if (ch_ff == '0) begin
         ch_eff = CRW'(1);
      end else if (CMP_W'(ch_ff) > CMP_W'(MAX_CANVAS_H)) begin
         ch_eff = CRW'(MAX_CANVAS_H);
      end else begin
         ch_eff = ch_ff;
      end
      sw_eff = (sw_ff == '0) ? SRW'(1) : sw_ff;
      sh_eff = (sh_ff == '0) ? SRW'(1) : sh_ff;
   end

   // Step = canvas * 256 / screen, one divider per axis.
   assign div_start = pending_ff && !busy_x && !busy_y;

   ics_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({cw_eff, {FW{1'b0}}}),
      .divisor  (sw_eff),
      .busy     (busy_x),
      .quotient (step_x)
   );

   ics_div u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({ch_eff, {FW{1'b0}}}),
      .divisor  (sh_eff),
      .busy     (busy_y),
      .quotient (step_y)
   );

   assign status.step_pending = pending_ff;
   assign status.step_busy    = busy_x || busy_y;

   // Intake: the scaled coordinates are multiplied on the way into the stage.
   assign req.ready = !pending_ff && !busy_x && !busy_y && (!st_valid_ff || st_done);
   assign req_fire  = req.valid && req.ready;
   assign prod_x_in = PRW'(req.pos_x) * PRW'(step_x);
   assign prod_y_in = PRW'(req.pos_y) * PRW'(step_y);

   // Classify the staged item into a command, or drop it.
   always_comb begin
      is_render = st_func_ff == ics_pkg::FUNC_RENDER;
      is_trans  = st_ci_ff == st_trans_ff;
      if (is_render && stretch_ff) begin
         coord_x = st_prod_x_ff[PRW-1:FW];
         coord_y = st_prod_y_ff[PRW-1:FW];
      end else begin
         coord_x = MW'(st_px_ff);
         coord_y = MW'(st_py_ff);
      end
      in_canvas = (coord_x < MW'(cw_eff)) && (coord_y < MW'(ch_eff));

      q_cmd.op  = ics_pkg::OP_RENDER;
      q_cmd.hit = in_canvas;
      q_cmd.idx = st_ci_ff;
      q_cmd.rgb = st_rgb_ff;
      need_push = 1'b0;
      case (st_func_ff)
         ics_pkg::FUNC_PALETTE: begin
            q_cmd.op  = ics_pkg::OP_PALETTE;
            need_push = PCW'(st_ci_ff) < PCW'(PALETTE_DEPTH);
         end
         ics_pkg::FUNC_CANVAS: begin
            q_cmd.op = ics_pkg::OP_CANVAS;
            if (st_restore_ff && is_trans) begin
               q_cmd.idx = st_bg_ff;
            end
            need_push = in_canvas && (st_restore_ff || !(st_trans_on_ff && is_trans));
         end
         ics_pkg::FUNC_RENDER: begin
            need_push = 1'b1;
         end
         default: begin
            need_push = 1'b0;
         end
      endcase
   end

   assign q_cx    = coord_x[CXW-1:0];
   assign q_cy    = coord_y[CYW-1:0];
   assign q_valid = st_valid_ff && need_push;
   assign st_done = !need_push || q_ready;

   always_comb begin
      if (req_fire) begin
         st_valid_in = 1'b1;
      end else if (st_done) begin
         st_valid_in = 1'b0;
      end else begin
         st_valid_in = st_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         st_func_ff     <= req.func;
         st_px_ff       <= req.pos_x;
         st_py_ff       <= req.pos_y;
         st_ci_ff       <= req.color_index;
         st_rgb_ff      <= req.rgb_value;
         st_trans_ff    <= req.transparent_index;
         st_trans_on_ff <= req.transparency_on;
         st_restore_ff  <= req.restore_background;
         st_bg_ff       <= req.background_index;
         st_prod_x_ff   <= prod_x_in;
         st_prod_y_ff   <= prod_y_in;
      end
      if (reset) begin
         cw_ff       <= CRW'(256);
         ch_ff       <= CRW'(256);
         sw_ff       <= SRW'(256);
         sh_ff       <= SRW'(256);
         stretch_ff  <= 1'b1;
         pending_ff  <= 1'b1;
         st_valid_ff <= 1'b0;
      end else begin
         cw_ff       <= cw_in;
         ch_ff       <= ch_in;
         sw_ff       <= sw_in;
         sh_ff       <= sh_in;
         stretch_ff  <= stretch_in;
         pending_ff  <= pending_in;
         st_valid_ff <= st_valid_in;
      end
   end

endmodule

/* rtl/ics_back.sv */
// Back part: carries out queued commands on the canvas and palette memories
// and holds the response register. Depends on ics_pkg, ics_channels, ics_ram.

module ics_back #(
   parameter int MAX_CANVAS_W  = ics_pkg::MAX_CANVAS_W_DEF,
   parameter int MAX_CANVAS_H  = ics_pkg::MAX_CANVAS_H_DEF,
   parameter int PALETTE_DEPTH = ics_pkg::PALETTE_DEPTH_DEF,
   localparam int CXW = $clog2(MAX_CANVAS_W),
   localparam int CYW = $clog2(MAX_CANVAS_H)
) (
   input  logic               clock,
   input  logic               reset,
   input  ics_pkg::cmd_type   cmd,
   input  logic [CXW-1:0]     cmd_cx,
   input  logic [CYW-1:0]     cmd_cy,
   input  logic               cmd_valid,
   output logic               cmd_ready,
   ics_rsp_if.source          rsp
);

   localparam int CANVAS_DEPTH = MAX_CANVAS_W * MAX_CANVAS_H;
   localparam int CAW = $clog2(CANVAS_DEPTH);
   localparam int PAW = $clog2(PALETTE_DEPTH);
   localparam int PCW = ics_pkg::INDEX_W + 1;
   localparam int IW  = ics_pkg::INDEX_W;
   localparam int RW  = ics_pkg::RGB_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_INDEX,
      S_RESULT
   } state_type;

   state_type                state_ff, state_in;
   logic                     hit_ff, hit_in;
   logic                     idx_ok_ff, idx_ok_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ics_pkg::ARGB_W-1:0] argb_ff, argb_in;
   logic                     covered_ff, covered_in;

   logic            cmd_fire;
   logic [CAW-1:0]  canvas_addr;
   logic            canvas_we, canvas_re;
   logic [IW-1:0]   canvas_rd;
   logic            pal_we, pal_re;
   logic [RW-1:0]   pal_rd;

   assign cmd_ready   = state_ff == S_IDLE;
   assign cmd_fire    = cmd_valid && cmd_ready;
   assign canvas_addr = CAW'(cmd_cy) * CAW'(MAX_CANVAS_W) + CAW'(cmd_cx);
   assign canvas_we   = cmd_fire && (cmd.op == ics_pkg::OP_CANVAS);
   assign canvas_re   = cmd_fire && (cmd.op == ics_pkg::OP_RENDER) && cmd.hit;
   assign pal_we      = cmd_fire && (cmd.op == ics_pkg::OP_PALETTE);
   assign pal_re      = state_ff == S_INDEX;

   ics_ram #(
      .WIDTH (IW),
      .DEPTH (CANVAS_DEPTH)
   ) u_canvas (
      .clock   (clock),
      .wr_en   (canvas_we),
      .wr_addr (canvas_addr),
      .wr_data (cmd.idx),
      .rd_en   (canvas_re),
      .rd_addr (canvas_addr),
      .rd_data (canvas_rd)
   );

   ics_ram #(
      .WIDTH (RW),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_we),
      .wr_addr (cmd.idx[PAW-1:0]),
      .wr_data (cmd.rgb),
      .rd_en   (pal_re),
      .rd_addr (canvas_rd[PAW-1:0]),
      .rd_data (pal_rd)
   );

   // Render sequence: canvas read, palette read, then the response register.
   always_comb begin
      state_in     = state_ff;
      hit_in       = hit_ff;
      idx_ok_in    = idx_ok_ff;
      argb_in      = argb_ff;
      covered_in   = covered_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      case (state_ff)
         S_IDLE: begin
            if (cmd_fire && (cmd.op == ics_pkg::OP_RENDER)) begin
               hit_in   = cmd.hit;
               state_in = cmd.hit ? S_INDEX : S_RESULT;
            end
         end
         S_INDEX: begin
            // An index beyond the palette reads as black.
            idx_ok_in = PCW'(canvas_rd) < PCW'(PALETTE_DEPTH);
            state_in  = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               covered_in   = hit_ff;
               if (hit_ff) begin
                  argb_in = {ics_pkg::ALPHA_OPAQUE, idx_ok_ff ? pal_rd : RW'(0)};
               end else begin
                  argb_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      hit_ff     <= hit_in;
      idx_ok_ff  <= idx_ok_in;
      argb_ff    <= argb_in;
      covered_ff <= covered_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.argb_pixel = argb_ff;
   assign rsp.covered    = covered_ff;

endmodule

/* rtl/indexed_canvas_scaler.sv */
// Indexed canvas scaler: palette and canvas stores with nearest-neighbor render.
// Top level; depends on ics_pkg, ics_channels, ics_front, ics_queue, ics_back.
//
// Usage:
//   req_chan carries palette writes, canvas pixel writes and render requests.
//   rsp_chan returns one beat per render request: the ARGB pixel and a covered
//   flag. Writes and unused selectors return nothing. csr_chan writes the size
//   and mode registers; it is always ready and is to be written only while the
//   block is idle.
// Flow:
//   The front part takes one request beat per cycle, while it is not held by
//   the step dividers or a full queue, into a register stage that also forms
//   the scaled coordinates, and queues it for the back part. The back part
//   runs one command at a time on the memories: a write goes to its store
//   directly; a render hit steps through canvas read, palette read and
//   response load, and a render miss goes straight to the response load.
// Reset and stalls: reset restores the register defaults; after reset and
//   after every CSR write, req_chan.ready stays low while the two step
//   dividers run. The stores hold nothing defined until written. A stalled
//   rsp_chan holds its beat; the queue keeps taking requests until it fills.

module indexed_canvas_scaler #(
   parameter int MAX_CANVAS_W  = ics_pkg::MAX_CANVAS_W_DEF,
   parameter int MAX_CANVAS_H  = ics_pkg::MAX_CANVAS_H_DEF,
   parameter int PALETTE_DEPTH = ics_pkg::PALETTE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ics_csr_if.sink    csr_chan,
   ics_req_if.sink    req_chan,
   ics_rsp_if.source  rsp_chan
);

   localparam int CXW = $clog2(MAX_CANVAS_W);
   localparam int CYW = $clog2(MAX_CANVAS_H);
   localparam int QW  = $bits(ics_pkg::cmd_type) + CXW + CYW;

   ics_pkg::cmd_type           push_cmd, pop_cmd;
   logic [CXW-1:0]             push_cx, pop_cx;
   logic [CYW-1:0]             push_cy, pop_cy;
   logic                       push_valid, push_ready;
   logic                       pop_valid, pop_ready;
   logic [QW-1:0]              pop_data;
   ics_pkg::front_status_type  front_status;

   ics_front #(
      .MAX_CANVAS_W  (MAX_CANVAS_W),
      .MAX_CANVAS_H  (MAX_CANVAS_H),
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .csr     (csr_chan),
      .req     (req_chan),
      .q_cmd   (push_cmd),
      .q_cx    (push_cx),
      .q_cy    (push_cy),
      .q_valid (push_valid),
      .q_ready (push_ready),
      .status  (front_status)
   );

   ics_queue #(
      .WIDTH (QW),
      .DEPTH (ics_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_cmd, push_cx, push_cy}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign {pop_cmd, pop_cx, pop_cy} = pop_data;

   ics_back #(
      .MAX_CANVAS_W  (MAX_CANVAS_W),
      .MAX_CANVAS_H  (MAX_CANVAS_H),
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (pop_cmd),
      .cmd_cx    (pop_cx),
      .cmd_cy    (pop_cy),
      .cmd_valid (pop_valid),
      .cmd_ready (pop_ready),
      .rsp       (rsp_chan)
   );

   // A request is never taken while the scaling steps are stale or in progress.
   a_accept_with_steps: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |->
         (!front_status.step_pending && !front_status.step_busy))
      else $error("request taken while scaling steps are not settled");

   // A covered pixel is opaque; an uncovered one is all zero.
   a_rsp_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.covered) |->
         (rsp_chan.argb_pixel[31:24] == ics_pkg::ALPHA_OPAQUE))
      else $error("covered pixel without opaque alpha");

   a_rsp_uncovered: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.covered) |-> (rsp_chan.argb_pixel == '0))
      else $error("uncovered pixel with nonzero color");

   // Reset leaves no response and blocks requests until the steps are computed.
   a_reset_state: assert property (@(posedge clock)
      reset |=> (!rsp_chan.valid && !req_chan.ready))
      else $error("response or request ready right after reset");

endmodule

/* verif/tb_indexed_canvas_scaler.sv */
// Self-checking testbench for indexed_canvas_scaler: palette, canvas and render beats.
// Depends on ics_pkg, the ics_channels interfaces and the indexed_canvas_scaler RTL.
// Expected pixels come from a behavioral copy of the stores and the scaling rules.

module tb_indexed_canvas_scaler;
   timeunit 1ns;
   timeprecision 1ps;

   // Sizes and field widths taken from the package.
   localparam int MAX_CANVAS_W_DEF  = ics_pkg::MAX_CANVAS_W_DEF;
   localparam int MAX_CANVAS_H_DEF  = ics_pkg::MAX_CANVAS_H_DEF;
   localparam int PALETTE_DEPTH_DEF = ics_pkg::PALETTE_DEPTH_DEF;
   localparam int POS_W             = ics_pkg::POS_W;
   localparam int INDEX_W           = ics_pkg::INDEX_W;
   localparam int RGB_W             = ics_pkg::RGB_W;
   localparam int ARGB_W            = ics_pkg::ARGB_W;
   localparam int FRAC_W            = ics_pkg::FRAC_W;
   localparam int CANVAS_REG_W      = ics_pkg::CANVAS_REG_W;
   localparam int SCREEN_REG_W      = ics_pkg::SCREEN_REG_W;
   localparam int CSR_INDEX_W       = ics_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W        = ics_pkg::CSR_DATA_W;

   localparam int CANVAS_ROW     = MAX_CANVAS_W_DEF;
   localparam int CANVAS_CELLS   = MAX_CANVAS_W_DEF * MAX_CANVAS_H_DEF;
   localparam int POS_MAX        = (1 << POS_W) - 1;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int LONG_HOLD      = 150;
   localparam int RANDOM_PER_SET = 35;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 3'd7;

   // One request beat as the sender builds it.
   typedef struct {
      ics_pkg::func_type   func;
      logic [POS_W-1:0]    pos_x;
      logic [POS_W-1:0]    pos_y;
      logic [INDEX_W-1:0]  color_index;
      logic [RGB_W-1:0]    rgb_value;
      logic [INDEX_W-1:0]  transparent_index;
      logic                transparency_on;
      logic                restore_background;
      logic [INDEX_W-1:0]  background_index;
   } pixel_req_type;

   // One expected response beat.
   typedef struct {
      logic [ARGB_W-1:0]   argb;
      logic                covered;
   } screen_pixel_type;

   logic clock;
   logic reset;

   ics_req_if req_chan ();
   ics_rsp_if rsp_chan ();
   ics_csr_if csr_chan ();

   indexed_canvas_scaler dut (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Behavioral copy of the stores and the size and mode registers.
   logic [RGB_W-1:0]        palette_model [PALETTE_DEPTH_DEF];
   logic [INDEX_W-1:0]      canvas_model [CANVAS_CELLS];
   bit                      canvas_written [CANVAS_CELLS];
   int unsigned             written_cells [$];
   logic [CANVAS_REG_W-1:0] canvas_w_reg;
   logic [CANVAS_REG_W-1:0] canvas_h_reg;
   logic [SCREEN_REG_W-1:0] screen_w_reg;
   logic [SCREEN_REG_W-1:0] screen_h_reg;
   logic                    stretch_reg;

   screen_pixel_type expected_pixels [$];
   int               error_count;
   int               idle_cycles;
   int               hold_request;
   bit               gaps_on;

   // Clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Effective sizes after clamping.
   function automatic int unsigned canvas_cols();
      if (canvas_w_reg == '0) return 1;
      if (canvas_w_reg > MAX_CANVAS_W_DEF) return MAX_CANVAS_W_DEF;
      return canvas_w_reg;
   endfunction

   function automatic int unsigned canvas_rows();
      if (canvas_h_reg == '0) return 1;
      if (canvas_h_reg > MAX_CANVAS_H_DEF) return MAX_CANVAS_H_DEF;
      return canvas_h_reg;
   endfunction

   function automatic int unsigned screen_cols();
      return (screen_w_reg == '0) ? 1 : screen_w_reg;
   endfunction

   function automatic int unsigned screen_rows();
      return (screen_h_reg == '0) ? 1 : screen_h_reg;
   endfunction

   // Step in 9.8 fixed point from canvas size to screen size.
   function automatic int unsigned scale_step(input int unsigned canvas, screen);
      return (canvas << FRAC_W) / screen;
   endfunction

   // Screen position to canvas position under the current mode.
   function automatic void map_screen(input int unsigned px, py,
                                      output int unsigned cx, cy);
      if (stretch_reg) begin
         cx = (px * scale_step(canvas_cols(), screen_cols())) >> FRAC_W;
         cy = (py * scale_step(canvas_rows(), screen_rows())) >> FRAC_W;
      end else begin
         cx = px;
         cy = py;
      end
   endfunction

   // Applies one accepted beat to the stores and queues the pixel it returns.
   function automatic void update_canvas_model(input pixel_req_type b);
      logic [INDEX_W-1:0] pix;
      bit                 store;
      int unsigned        addr;
      int unsigned        cx;
      int unsigned        cy;
      screen_pixel_type   result;
      case (b.func)
         ics_pkg::FUNC_PALETTE: begin
            palette_model[b.color_index] = b.rgb_value;
         end
         ics_pkg::FUNC_CANVAS: begin
            if (b.pos_x < canvas_cols() && b.pos_y < canvas_rows()) begin
               pix = b.color_index;
               store = 1'b1;
               // Restore-to-background wins over transparency.
               if (b.restore_background) begin
                  if (pix == b.transparent_index) pix = b.background_index;
               end else if (b.transparency_on && pix == b.transparent_index) begin
                  store = 1'b0;
               end
               if (store) begin
                  addr = b.pos_y * CANVAS_ROW + b.pos_x;
                  canvas_model[addr] = pix;
                  if (!canvas_written[addr]) begin
                     canvas_written[addr] = 1'b1;
                     written_cells.push_back(addr);
                  end
               end
            end
         end
         ics_pkg::FUNC_RENDER: begin
            map_screen(b.pos_x, b.pos_y, cx, cy);
            if (cx >= canvas_cols() || cy >= canvas_rows()) begin
               result.argb = '0;
               result.covered = 1'b0;
            end else begin
               pix = canvas_model[cy * CANVAS_ROW + cx];
               result.argb = {ics_pkg::ALPHA_OPAQUE, palette_model[pix]};
               result.covered = 1'b1;
            end
            expected_pixels.push_back(result);
         end
         default: begin
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [ARGB_W-1:0] got, want);
      $display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   // Sends one request beat, after a random gap when gaps are on, and records it once taken.
   task automatic send_beat(input pixel_req_type b);
      int gap;
      gap = gaps_on ? $urandom_range(4, 0) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid              <= 1'b1;
      req_chan.func               <= b.func;
      req_chan.pos_x              <= b.pos_x;
      req_chan.pos_y              <= b.pos_y;
      req_chan.color_index        <= b.color_index;
      req_chan.rgb_value          <= b.rgb_value;
      req_chan.transparent_index  <= b.transparent_index;
      req_chan.transparency_on    <= b.transparency_on;
      req_chan.restore_background <= b.restore_background;
      req_chan.background_index   <= b.background_index;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      update_canvas_model(b);
   endtask

   // Writes one register and mirrors it into the model.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_chan.valid      <= 1'b1;
      csr_chan.reg_index  <= idx;
      csr_chan.write_data <= data;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      case (idx)
         ics_pkg::REG_CANVAS_W: canvas_w_reg = data[CANVAS_REG_W-1:0];
         ics_pkg::REG_CANVAS_H: canvas_h_reg = data[CANVAS_REG_W-1:0];
         ics_pkg::REG_SCREEN_W: screen_w_reg = data[SCREEN_REG_W-1:0];
         ics_pkg::REG_SCREEN_H: screen_h_reg = data[SCREEN_REG_W-1:0];
         ics_pkg::REG_STRETCH:  stretch_reg = data[0];
         default: begin
         end
      endcase
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until every pixel is back and trailing writes have retired.
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [CSR_DATA_W-1:0] cw, ch, sw, sh, st);
      wait_idle();
      write_reg(ics_pkg::REG_CANVAS_W, cw);
      write_reg(ics_pkg::REG_CANVAS_H, ch);
      write_reg(ics_pkg::REG_SCREEN_W, sw);
      write_reg(ics_pkg::REG_SCREEN_H, sh);
      write_reg(ics_pkg::REG_STRETCH, st);
   endtask

   function automatic pixel_req_type make_beat(input ics_pkg::func_type f,
                                               input int unsigned x, y, ci, rgb, ti,
                                               input bit ton, rb,
                                               input int unsigned bg);
      pixel_req_type b;
      b.func               = f;
      b.pos_x              = POS_W'(x);
      b.pos_y              = POS_W'(y);
      b.color_index        = INDEX_W'(ci);
      b.rgb_value          = RGB_W'(rgb);
      b.transparent_index  = INDEX_W'(ti);
      b.transparency_on    = ton;
      b.restore_background = rb;
      b.background_index   = INDEX_W'(bg);
      return b;
   endfunction

   function automatic pixel_req_type random_fields();
      return make_beat(ics_pkg::func_type'($urandom_range(3, 0)),
                       $urandom_range(POS_MAX, 0),
                       $urandom_range(POS_MAX, 0), $urandom_range(255, 0), $urandom,
                       $urandom_range(255, 0), $urandom_range(1, 0), $urandom_range(1, 0),
                       $urandom_range(255, 0));
   endfunction

   // Screen coordinate that maps onto one canvas cell along one axis.
   function automatic bit screen_pos_for(input int unsigned target, canvas, screen,
                                         output logic [POS_W-1:0] pos);
      int unsigned step;
      int unsigned lo;
      int unsigned hi;
      if (!stretch_reg) begin
         pos = POS_W'(target);
         return 1'b1;
      end
      step = scale_step(canvas, screen);
      if (step == 0) begin
         // Every screen position lands on cell zero.
         pos = POS_W'($urandom_range(POS_MAX, 0));
         return target == 0;
      end
      lo = ((target << FRAC_W) + step - 1) / step;
      hi = (((target + 1) << FRAC_W) + step - 1) / step - 1;
      if (hi > POS_MAX) hi = POS_MAX;
      if (lo > hi) return 1'b0;
      pos = POS_W'($urandom_range(hi, lo));
      return 1'b1;
   endfunction

   // Picks a render position that never reads a canvas cell left unwritten.
   function automatic bit pick_render_pos(output logic [POS_W-1:0] px, py);
      int unsigned span_x;
      int unsigned span_y;
      int unsigned cx;
      int unsigned cy;
      int unsigned addr;
      span_x = stretch_reg ? screen_cols() + 2 : canvas_cols() + 2;
      span_y = stretch_reg ? screen_rows() + 2 : canvas_rows() + 2;
      if (span_x > POS_MAX) span_x = POS_MAX;
      if (span_y > POS_MAX) span_y = POS_MAX;
      // Free search first: covered pixels and misses alike.
      for (int t = 0; t < 12; t++) begin
         if ($urandom_range(7, 0) == 0) begin
            px = POS_W'($urandom_range(POS_MAX, 0));
            py = POS_W'($urandom_range(POS_MAX, 0));
         end else begin
            px = POS_W'($urandom_range(span_x, 0));
            py = POS_W'($urandom_range(span_y, 0));
         end
         map_screen(px, py, cx, cy);
         if (cx >= canvas_cols() || cy >= canvas_rows()) return 1'b1;
         if (canvas_written[cy * CANVAS_ROW + cx]) return 1'b1;
      end
      // Then aim at a cell that is known to hold a pixel.
      for (int t = 0; t < 32 && written_cells.size() > 0; t++) begin
         addr = written_cells[$urandom_range(written_cells.size() - 1, 0)];
         cx = addr % CANVAS_ROW;
         cy = addr / CANVAS_ROW;
         if (cx < canvas_cols() && cy < canvas_rows() &&
             screen_pos_for(cx, canvas_cols(), screen_cols(), px) &&
             screen_pos_for(cy, canvas_rows(), screen_rows(), py))
            return 1'b1;
      end
      return 1'b0;
   endfunction

   // One random beat: mostly canvas writes and renders, some palette writes and noise.
   task automatic send_random_item();
      pixel_req_type b;
      int unsigned   pick;
      b = random_fields();
      pick = $urandom_range(99, 0);
      if (pick < 8) begin
         b.func = ics_pkg::FUNC_PALETTE;
      end else if (pick < 12) begin
         b.func = ics_pkg::FUNC_NONE;
      end else if (pick < 50) begin
         b.func = ics_pkg::FUNC_CANVAS;
         if ($urandom_range(9, 0) != 0) begin
            b.pos_x = POS_W'($urandom_range(canvas_cols() - 1, 0));
            b.pos_y = POS_W'($urandom_range(canvas_rows() - 1, 0));
         end
         if ($urandom_range(2, 0) == 0) b.color_index = b.transparent_index;
      end else begin
         b.func = ics_pkg::FUNC_RENDER;
         if (!pick_render_pos(b.pos_x, b.pos_y)) begin
            // Nothing readable yet: plant an opaque pixel instead.
            b.func = ics_pkg::FUNC_CANVAS;
            b.pos_x = POS_W'($urandom_range(canvas_cols() - 1, 0));
            b.pos_y = POS_W'($urandom_range(canvas_rows() - 1, 0));
            b.transparency_on = 1'b0;
            b.restore_background = 1'b0;
         end
      end
      send_beat(b);
   endtask

   // Fills every palette entry so that any stored index can be looked up.
   task automatic test_palette_load();
      gaps_on = 1'b1;
      send_beat(make_beat(ics_pkg::FUNC_PALETTE, 0, 0, 0, 24'h000000, 0, 0, 0, 0));
      for (int e = 1; e < PALETTE_DEPTH_DEF - 1; e++)
         send_beat(make_beat(ics_pkg::FUNC_PALETTE, 0, 0, e, $urandom, 0, 0, 0, 0));
      send_beat(make_beat(ics_pkg::FUNC_PALETTE, POS_MAX, POS_MAX, 255, 24'hFFFFFF,
                          255, 1, 1, 255));
   endtask

   // Compositing rules, canvas edges and misses under the reset setting.
   task automatic test_directed();
      // Plain write, then a write at the far corner.
      send_beat(make_beat(ics_pkg::FUNC_CANVAS, 0, 0, 7, 0, 0, 0, 0, 0));
      send_beat(make_beat(ics_pkg::FUNC_CANVAS, 255, 255, 255, 0, 0, 1, 0, 0));
      // A transparent pixel with transparency on leaves the cell alone.
      send_beat(make_beat(ics_pkg::FUNC_CANVAS, 0, 0, 9, 0, 9, 1, 0, 0));
      send_beat(make_beat(ics_pkg::FUNC_RENDER, 0, 0, 0, 0, 0, 0, 0, 0));
      // Restore-to-background turns a transparent pixel into the background index.
      send_beat(make_beat(ics_pkg::FUNC_CANVAS, 255, 255, 3, 0, 3, 0, 1, 200));
      send_beat(make_beat(ics_pkg::FUNC_RENDER, 255, 255, 0, 0, 0, 0, 0, 0));
      send_beat(make_beat(ics_pkg::FUNC_CANVAS, 1, 0, 4, 0, 5, 1, 1, 0));
      send_beat(make_beat(ics_pkg::FUNC_CANVAS, 1, 0, 6, 0, 6, 1, 1, 0));
      send_beat(make_beat(ics_pkg::FUNC_RENDER, 1, 0, 0, 0, 0, 0, 0, 0));
      // Writes beyond the canvas must not wrap into the next row.
      send_beat(make_beat(ics_pkg::FUNC_CANVAS, 0, 1, 50, 0, 0, 0, 0, 0));
      send_beat(make_beat(ics_pkg::FUNC_CANVAS, 256, 0, 1, 0, 0, 0, 0, 0));
      send_beat(make_beat(ics_pkg::FUNC_CANVAS, 0, POS_MAX, 2, 0, 0, 0, 0, 0));
      send_beat(make_beat(ics_pkg::FUNC_CANVAS, POS_MAX, POS_MAX, 3, 0, 0, 0, 0, 0));
      send_beat(make_beat(ics_pkg::FUNC_RENDER, 0, 1, 0, 0, 0, 0, 0, 0));
      // Screen positions past the screen are not covered.
      send_beat(make_beat(ics_pkg::FUNC_RENDER, 256, 0, 0, 0, 0, 0, 0, 0));
      send_beat(make_beat(ics_pkg::FUNC_RENDER, 0, 256, 0, 0, 0, 0, 0, 0));
      send_beat(make_beat(ics_pkg::FUNC_RENDER, POS_MAX, POS_MAX, 0, 0, 0, 0, 0, 0));
      // The unused selector does nothing.
      send_beat(make_beat(ics_pkg::FUNC_NONE, 0, 0, 0, 24'hFFFFFF, 0, 1, 1, 0));
      // A palette rewrite shows up on the next render.
      send_beat(make_beat(ics_pkg::FUNC_PALETTE, 0, 0, 7, 24'h123456, 0, 0, 0, 0));
      send_beat(make_beat(ics_pkg::FUNC_RENDER, 0, 0, 0, 0, 0, 0, 0, 0));
   endtask

   // The receiver holds off for a long stretch while renders keep coming.
   task automatic test_backpressure();
      pixel_req_type b;
      gaps_on = 1'b0;
      hold_request = LONG_HOLD;
      for (int n = 0; n < 40; n++) begin
         b = random_fields();
         b.func = ics_pkg::FUNC_RENDER;
         if (!pick_render_pos(b.pos_x, b.pos_y)) b.func = ics_pkg::FUNC_PALETTE;
         send_beat(b);
      end
      gaps_on = 1'b1;
   endtask

   task automatic run_setting(input logic [CSR_DATA_W-1:0] cw, ch, sw, sh, st);
      apply_setting(cw, ch, sw, sh, st);
      for (int n = 0; n < RANDOM_PER_SET; n++) send_random_item();
   endtask

   // Random traffic across size and mode settings, extremes included.
   task automatic test_settings();
      gaps_on = 1'b1;
      run_setting(12'd1, 12'd1, 12'd1, 12'd1, 12'd1);
      // Zero sizes clamp to one; an even value selects one-to-one.
      run_setting(12'd0, 12'd0, 12'd0, 12'd0, 12'hFFE);
      gaps_on = 1'b0;
      run_setting(12'd8, 12'd6, 12'd2048, 12'd2048, 12'd1);
      gaps_on = 1'b1;
      run_setting(12'd256, 12'd256, 12'd1, 12'd1, 12'd1);
      // Oversized canvas registers clamp to the store size.
      run_setting(12'd300, 12'hFFF, 12'd100, 12'd37, 12'd1);
      run_setting(12'hE05, 12'hE09, 12'hFFF, 12'd2048, 12'hFFF);
      gaps_on = 1'b0;
      run_setting(12'd12, 12'd9, 12'd640, 12'd480, 12'd0);
      gaps_on = 1'b1;
      run_setting(12'd16, 12'd16, 12'd48, 12'd20, 12'd1);
      run_setting(12'd200, 12'd150, 12'd160, 12'd120, 12'd1);
      run_setting(12'd5, 12'd200, 12'd640, 12'd480, 12'd0);
      run_setting(12'd256, 12'd256, 12'd256, 12'd256, 12'd1);
      // A write to an index with no register behind it changes nothing.
      wait_idle();
      write_reg(REG_UNUSED, 12'hFFF);
      for (int n = 0; n < 20; n++) send_random_item();
   endtask

   // Receiver: random stalls, or one long hold-off when asked for.
   initial begin : pixel_sink
      int stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request > 0) begin
            stall = hold_request;
            hold_request = 0;
         end else begin
            stall = gaps_on ? $urandom_range(4, 0) : 0;
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
      end
   end

   // Compares each response beat with the oldest expected pixel.
   always @(posedge clock) begin : pixel_check
      screen_pixel_type want;
      if (reset === 1'b0 && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected response beat", rsp_chan.argb_pixel, '0);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_chan.argb_pixel !== want.argb)
               report_mismatch("argb_pixel", rsp_chan.argb_pixel, want.argb);
            if (rsp_chan.covered !== want.covered)
               report_mismatch("covered", ARGB_W'(rsp_chan.covered), ARGB_W'(want.covered));
         end
      end
   end

   // Watchdog: ends the run when no beat moves on any channel for too long.
   always @(posedge clock) begin
      if (reset !== 1'b0 ||
          (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) ||
          (csr_chan.valid === 1'b1 && csr_chan.ready === 1'b1)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_indexed_canvas_scaler: FAIL");
            $finish;
         end
      end
   end

   // Reset, then the tests in turn, then the final verdict.
   initial begin : test_sequence
      error_count  = 0;
      idle_cycles  = 0;
      hold_request = 0;
      gaps_on      = 1'b1;
      canvas_w_reg = CANVAS_REG_W'(MAX_CANVAS_W_DEF);
      canvas_h_reg = CANVAS_REG_W'(MAX_CANVAS_H_DEF);
      screen_w_reg = SCREEN_REG_W'(256);
      screen_h_reg = SCREEN_REG_W'(256);
      stretch_reg  = 1'b1;
      reset                       <= 1'b1;
      req_chan.valid              <= 1'b0;
      req_chan.func               <= ics_pkg::FUNC_NONE;
      req_chan.pos_x              <= '0;
      req_chan.pos_y              <= '0;
      req_chan.color_index        <= '0;
      req_chan.rgb_value          <= '0;
      req_chan.transparent_index  <= '0;
      req_chan.transparency_on    <= 1'b0;
      req_chan.restore_background <= 1'b0;
      req_chan.background_index   <= '0;
      csr_chan.valid              <= 1'b0;
      csr_chan.reg_index          <= ics_pkg::REG_CANVAS_W;
      csr_chan.write_data         <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_palette_load();
      test_directed();
      test_backpressure();
      test_settings();

      wait_idle();
      if (expected_pixels.size() != 0)
         report_mismatch("pixels never returned", ARGB_W'(expected_pixels.size()), '0);
      if (error_count == 0) begin
         $display("tb_indexed_canvas_scaler: PASS");
      end else begin
         $display("tb_indexed_canvas_scaler: FAIL");
      end
      $finish;
   end

endmodule
